@@ sv/wwg_pkg.sv @@
// Shared types and constants for the Wireworld grid engine.
// Used by every module of the block; depends on nothing.

package wwg_pkg;

   localparam int DEF_MAX_ROWS = 32;
   localparam int DEF_MAX_COLS = 64;

   localparam int ROWS_USED_W = 6;
   localparam int COLS_USED_W = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [ROWS_USED_W-1:0] ROWS_USED_RESET = 6'd20;
   localparam logic [COLS_USED_W-1:0] COLS_USED_RESET = 7'd40;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_USED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_USED = 2'd1;

   typedef enum logic [1:0] {
      CELL_EMPTY = 2'd0,
      CELL_COND  = 2'd1,
      CELL_HEAD  = 2'd2,
      CELL_TAIL  = 2'd3
   } cell_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_STEP  = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_READ
   } state_type;

   // 3x3 neighborhood around the cell being updated
   typedef struct packed {
      cell_type nw;
      cell_type n;
      cell_type ne;
      cell_type w;
      cell_type c;
      cell_type e;
      cell_type sw;
      cell_type s;
      cell_type se;
   } window_type;

   // which sides of the window fall off the grid
   typedef struct packed {
      logic top;
      logic left;
      logic right;
   } bound_type;

endpackage

@@ sv/wwg_cell.sv @@
// One stage of the neighborhood shift line: holds one two-bit cell state.
// Depends on wwg_pkg.

module wwg_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  wwg_pkg::cell_type d_in,
   output wwg_pkg::cell_type q
);

   wwg_pkg::cell_type q_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         q_ff <= d_in;
      end
   end

   assign q = q_ff;

endmodule

@@ sv/wwg_chain.sv @@
// Row of wwg_cell stages spanning two grid rows plus three cells; exposes
// the 3x3 window around the middle tap. Depends on wwg_pkg and wwg_cell.

module wwg_chain #(
   parameter int MAX_COLS = wwg_pkg::DEF_MAX_COLS
) (
   input  logic                clock,
   input  logic                shift_en,
   input  wwg_pkg::cell_type   d_in,
   output wwg_pkg::window_type win
);

   localparam int CHAIN_LEN = 2 * MAX_COLS + 3;

   wwg_pkg::cell_type tap [CHAIN_LEN];

   for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_stage
      if (i == 0) begin : g_head
         wwg_cell u_stage (
            .clock    (clock),
            .shift_en (shift_en),
            .d_in     (d_in),
            .q        (tap[i])
         );
      end else begin : g_body
         wwg_cell u_stage (
            .clock    (clock),
            .shift_en (shift_en),
            .d_in     (tap[i-1]),
            .q        (tap[i])
         );
      end
   end

   // newest word is the south-east neighbor of the middle tap
   assign win.se = tap[0];
   assign win.s  = tap[1];
   assign win.sw = tap[2];
   assign win.e  = tap[MAX_COLS];
   assign win.c  = tap[MAX_COLS+1];
   assign win.w  = tap[MAX_COLS+2];
   assign win.ne = tap[2*MAX_COLS];
   assign win.n  = tap[2*MAX_COLS+1];
   assign win.nw = tap[2*MAX_COLS+2];

endmodule

@@ sv/wwg_rule.sv @@
// Wireworld transition for one cell from its 3x3 window and edge flags.
// Depends on wwg_pkg.

module wwg_rule (
   input  wwg_pkg::window_type win,
   input  wwg_pkg::bound_type  bnd,
   output wwg_pkg::cell_type   next_state
);

   logic [7:0] head_bits;
   logic [3:0] heads;

   always_comb begin
      head_bits[0] = (win.nw == wwg_pkg::CELL_HEAD) && !bnd.top && !bnd.left;
      head_bits[1] = (win.n  == wwg_pkg::CELL_HEAD) && !bnd.top;
      head_bits[2] = (win.ne == wwg_pkg::CELL_HEAD) && !bnd.top && !bnd.right;
      head_bits[3] = (win.w  == wwg_pkg::CELL_HEAD) && !bnd.left;
      head_bits[4] = (win.e  == wwg_pkg::CELL_HEAD) && !bnd.right;
      head_bits[5] = (win.sw == wwg_pkg::CELL_HEAD) && !bnd.left;
      head_bits[6] = (win.s  == wwg_pkg::CELL_HEAD);
      head_bits[7] = (win.se == wwg_pkg::CELL_HEAD) && !bnd.right;
   end

   always_comb begin
      heads = 4'd0;
      for (int i = 0; i < 8; i++) begin
         heads = heads + 4'(head_bits[i]);
      end
   end

   always_comb begin
      unique case (win.c)
         wwg_pkg::CELL_EMPTY: next_state = wwg_pkg::CELL_EMPTY;
         wwg_pkg::CELL_COND: begin
            if (heads == 4'd1 || heads == 4'd2) begin
               next_state = wwg_pkg::CELL_HEAD;
            end else begin
               next_state = wwg_pkg::CELL_COND;
            end
         end
         wwg_pkg::CELL_HEAD:  next_state = wwg_pkg::CELL_TAIL;
         wwg_pkg::CELL_TAIL:  next_state = wwg_pkg::CELL_COND;
      endcase
   end

endmodule

@@ sv/wireworld_grid_engine_core.sv @@
// Wireworld grid engine top level: grid memory, sweep control, config
// registers and result register. Depends on wwg_pkg, wwg_chain, wwg_rule.

// Usage:
//  req_* carries one command word: write cell, step one generation, read
//  cell (opcode three is a no-op). A word is taken when req_valid is high
//  and req_stall low. rsp_* returns one word per read only.
//  csr_* writes rows_used (index 0) and cols_used (index 1); csr_ready is
//  always high. Write it only while the block is idle.
//  Write and no-op complete without leaving the idle state. A read passes
//  the memory read register, then the output register, to rsp_valid;
//  while a read result waits, writes and steps are still taken.
//  A step streams the grid in raster order, one cell per cycle, through a
//  shift line of 2*MAX_COLS+3 cells and updates each cell in place behind
//  the window. An empty region does not start a sweep.
//  After reset the grid memory is cleared one cell per cycle, with req_stall high.
//  A stalled result holds in the output register; a second read then
//  waits in the block with req_stall high until the first word is taken.

module wireworld_grid_engine_core #(
   parameter int MAX_ROWS = wwg_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = wwg_pkg::DEF_MAX_COLS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_opcode,
   input  logic [4:0]                      req_row,
   input  logic [5:0]                      req_col,
   input  logic [1:0]                      req_new_state,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_cell_state,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wwg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wwg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int NR_W    = $clog2(MAX_ROWS + 1);
   localparam int NC_W    = $clog2(MAX_COLS + 1);
   localparam int LAG     = MAX_COLS + 3;
   localparam int LAG_W   = $clog2(LAG);
   localparam int FROW_W  = $clog2(MAX_ROWS + 2);
   localparam int FADDR_W = $clog2((MAX_ROWS + 2) * MAX_COLS);

   wwg_pkg::state_type state_ff, state_in;

   logic [wwg_pkg::ROWS_USED_W-1:0] rows_used_ff, rows_used_in;
   logic [wwg_pkg::COLS_USED_W-1:0] cols_used_ff, cols_used_in;

   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [NR_W-1:0]    nr_ff, nr_in, nr_eff;
   logic [NC_W-1:0]    nc_ff, nc_in, nc_eff;
   logic [FROW_W-1:0]  f_row_ff, f_row_in;
   logic [COL_W-1:0]   f_col_ff, f_col_in;
   logic [FADDR_W-1:0] f_addr_ff, f_addr_in;
   logic               f_inside;
   logic [LAG_W-1:0]   lag_ff, lag_in;
   logic               cen_run_ff, cen_run_in;
   logic [ROW_W-1:0]   cen_row_ff, cen_row_in;
   logic [COL_W-1:0]   cen_col_ff, cen_col_in;
   logic [ADDR_W-1:0]  cen_addr_ff, cen_addr_in;
   logic               d_inside_ff;
   logic               rd_inside_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   wwg_pkg::cell_type  rsp_state_ff, rsp_state_in;

   wwg_pkg::cell_type  grid_mem [DEPTH];
   wwg_pkg::cell_type  rdata_ff;
   logic               rd_en, wr_en;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   wwg_pkg::cell_type  wr_data;

   logic               req_inside;
   logic [ADDR_W-1:0]  req_addr;
   wwg_pkg::op_type    req_op;

   wwg_pkg::cell_type  chain_d;
   logic               shift_en;
   wwg_pkg::window_type win;
   wwg_pkg::bound_type bnd;
   wwg_pkg::cell_type  rule_state;

   // ---------------- request decode ----------------
   assign req_op     = wwg_pkg::op_type'(req_opcode);
   assign req_inside = (int'(req_row) < MAX_ROWS) && (int'(req_col) < MAX_COLS);
   assign req_addr   = ADDR_W'(ADDR_W'(req_row) * ADDR_W'(MAX_COLS)) + ADDR_W'(req_col);

   always_comb begin
      if (int'(rows_used_ff) > MAX_ROWS) begin
         nr_eff = NR_W'(MAX_ROWS);
      end else begin
         nr_eff = NR_W'(rows_used_ff);
      end
      if (int'(cols_used_ff) > MAX_COLS) begin
         nc_eff = NC_W'(MAX_COLS);
      end else begin
         nc_eff = NC_W'(cols_used_ff);
      end
   end

   // ---------------- config registers ----------------
   always_comb begin
      rows_used_in = rows_used_ff;
      cols_used_in = cols_used_ff;
      if (csr_valid) begin
         unique case (csr_index)
            wwg_pkg::CSR_ROWS_USED: rows_used_in = csr_wdata[wwg_pkg::ROWS_USED_W-1:0];
            wwg_pkg::CSR_COLS_USED: cols_used_in = csr_wdata[wwg_pkg::COLS_USED_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // ---------------- neighborhood window ----------------
   assign f_inside = (f_row_ff < FROW_W'(nr_ff)) && (NC_W'(f_col_ff) < nc_ff);
   assign shift_en = (state_ff == wwg_pkg::ST_STEP);
   assign chain_d  = d_inside_ff ? rdata_ff : wwg_pkg::CELL_EMPTY;

   wwg_chain #(
      .MAX_COLS (MAX_COLS)
   ) u_chain (
      .clock    (clock),
      .shift_en (shift_en),
      .d_in     (chain_d),
      .win      (win)
   );

   assign bnd.top   = (cen_row_ff == '0);
   assign bnd.left  = (cen_col_ff == '0);
   assign bnd.right = (cen_col_ff == COL_W'(MAX_COLS - 1));

   wwg_rule u_rule (
      .win        (win),
      .bnd        (bnd),
      .next_state (rule_state)
   );

   // ---------------- control ----------------
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      nr_in       = nr_ff;
      nc_in       = nc_ff;
      f_row_in    = f_row_ff;
      f_col_in    = f_col_ff;
      f_addr_in   = f_addr_ff;
      lag_in      = lag_ff;
      cen_run_in  = cen_run_ff;
      cen_row_in  = cen_row_ff;
      cen_col_in  = cen_col_ff;
      cen_addr_in = cen_addr_ff;
      req_stall   = 1'b1;
      rd_en       = 1'b0;
      rd_addr     = req_addr;
      wr_en       = 1'b0;
      wr_addr     = req_addr;
      wr_data     = wwg_pkg::cell_type'(req_new_state);

      unique case (state_ff)
         wwg_pkg::ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = wwg_pkg::CELL_EMPTY;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = wwg_pkg::ST_IDLE;
            end
         end

         wwg_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (req_op)
                  wwg_pkg::OP_WRITE: wr_en = req_inside;
                  wwg_pkg::OP_STEP: begin
                     nr_in       = nr_eff;
                     nc_in       = nc_eff;
                     f_row_in    = '0;
                     f_col_in    = '0;
                     f_addr_in   = '0;
                     lag_in      = '0;
                     cen_run_in  = 1'b0;
                     cen_row_in  = '0;
                     cen_col_in  = '0;
                     cen_addr_in = '0;
                     if (nr_eff != '0 && nc_eff != '0) begin
                        state_in = wwg_pkg::ST_STEP;
                     end
                  end
                  wwg_pkg::OP_READ: begin
                     rd_en    = 1'b1;
                     state_in = wwg_pkg::ST_READ;
                  end
                  wwg_pkg::OP_NOP: ;
               endcase
            end
         end

         wwg_pkg::ST_READ: begin
            // hold the read word until the output register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = wwg_pkg::ST_IDLE;
            end
         end

         wwg_pkg::ST_STEP: begin
            rd_en     = 1'b1;
            rd_addr   = f_addr_ff[ADDR_W-1:0];
            f_addr_in = f_addr_ff + 1'b1;
            if (f_col_ff == COL_W'(MAX_COLS - 1)) begin
               f_col_in = '0;
               f_row_in = f_row_ff + 1'b1;
            end else begin
               f_col_in = f_col_ff + 1'b1;
            end

            if (!cen_run_ff) begin
               // wait for the first cell to reach the middle tap
               lag_in = lag_ff + 1'b1;
               if (lag_ff == LAG_W'(LAG - 1)) begin
                  cen_run_in = 1'b1;
               end
            end else begin
               wr_en       = (NC_W'(cen_col_ff) < nc_ff);
               wr_addr     = cen_addr_ff;
               wr_data     = rule_state;
               cen_addr_in = cen_addr_ff + 1'b1;
               if (cen_col_ff == COL_W'(MAX_COLS - 1)) begin
                  cen_col_in = '0;
                  cen_row_in = cen_row_ff + 1'b1;
                  if (NR_W'(cen_row_ff) + NR_W'(1) == nr_ff) begin
                     state_in = wwg_pkg::ST_IDLE;
                  end
               end else begin
                  cen_col_in = cen_col_ff + 1'b1;
               end
            end
         end
      endcase
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_state_in = rsp_state_ff;
      if (state_ff == wwg_pkg::ST_READ && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in = 1'b1;
         rsp_state_in = rd_inside_ff ? rdata_ff : wwg_pkg::CELL_EMPTY;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_state = rsp_state_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wwg_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rows_used_ff <= wwg_pkg::ROWS_USED_RESET;
         cols_used_ff <= wwg_pkg::COLS_USED_RESET;
         rsp_valid_ff <= 1'b0;
         cen_run_ff   <= 1'b0;
         lag_ff       <= '0;
         nr_ff        <= '0;
         nc_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rows_used_ff <= rows_used_in;
         cols_used_ff <= cols_used_in;
         rsp_valid_ff <= rsp_valid_in;
         cen_run_ff   <= cen_run_in;
         lag_ff       <= lag_in;
         nr_ff        <= nr_in;
         nc_ff        <= nc_in;
      end
   end

   always_ff @(posedge clock) begin
      f_row_ff     <= f_row_in;
      f_col_ff     <= f_col_in;
      f_addr_ff    <= f_addr_in;
      cen_row_ff   <= cen_row_in;
      cen_col_ff   <= cen_col_in;
      cen_addr_ff  <= cen_addr_in;
      d_inside_ff  <= f_inside;
      rsp_state_ff <= rsp_state_in;
      if (rd_en) begin
         rd_inside_ff <= req_inside;
      end
   end

   // grid memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= grid_mem[rd_addr];
      end
   end

`ifndef SYNTHESIS
   a_step_ports_apart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wwg_pkg::ST_STEP) && wr_en |-> (wr_addr != rd_addr))
      else $error("step write collides with window fetch");

   a_read_goes_to_read: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == wwg_pkg::OP_READ)
      |=> (state_ff == wwg_pkg::ST_READ))
      else $error("accepted read did not enter read state");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == wwg_pkg::ST_READ))
      else $error("result word without a read");

   a_step_region_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wwg_pkg::ST_STEP) |-> (nr_ff != '0) && (nc_ff != '0))
      else $error("step running over an empty region");
`endif

endmodule

@@ tb/sv/tb_wireworld_grid_engine_core.sv @@
// Self-checking testbench for wireworld_grid_engine_core: cell writes, reads and
// generation steps checked against a grid predictor kept in this file.
// Depends on wwg_pkg and the core RTL only.

module tb_wireworld_grid_engine_core;

   localparam int GRID_ROWS     = wwg_pkg::DEF_MAX_ROWS;
   localparam int GRID_COLS     = wwg_pkg::DEF_MAX_COLS;
   // the longest step sweep fits inside this with room to spare
   localparam int SETTLE_CYCLES = GRID_COLS + 3 + GRID_ROWS * GRID_COLS + 32;
   localparam int CYCLE_LIMIT   = 3_000_000;

   localparam logic [wwg_pkg::CSR_IDX_W-1:0] CSR_IDX_SPARE_LO = 2'd2;
   localparam logic [wwg_pkg::CSR_IDX_W-1:0] CSR_IDX_SPARE_HI = 2'd3;

   logic                           clock;
   logic                           reset         = 1'b1;
   logic                           req_valid     = 1'b0;
   logic                           req_stall;
   logic [1:0]                     req_opcode    = wwg_pkg::OP_NOP;
   logic [4:0]                     req_row       = '0;
   logic [5:0]                     req_col       = '0;
   logic [1:0]                     req_new_state = wwg_pkg::CELL_EMPTY;
   logic                           rsp_valid;
   logic                           rsp_stall     = 1'b0;
   logic [1:0]                     rsp_cell_state;
   logic                           csr_valid     = 1'b0;
   logic                           csr_ready;
   logic [wwg_pkg::CSR_IDX_W-1:0]  csr_index     = '0;
   logic [wwg_pkg::CSR_DATA_W-1:0] csr_wdata     = '0;

   // grid predictor state
   wwg_pkg::cell_type               grid_model [GRID_ROWS][GRID_COLS];
   logic [wwg_pkg::ROWS_USED_W-1:0] rows_cfg = wwg_pkg::ROWS_USED_RESET;
   logic [wwg_pkg::COLS_USED_W-1:0] cols_cfg = wwg_pkg::COLS_USED_RESET;
   wwg_pkg::cell_type               pending_cell_reads [$];

   int                    send_idle_pct  = 0;
   int                    recv_stall_pct = 0;
   int                    mismatch_count = 0;
   int                    cycle_count    = 0;
   int                    phase_count    = 0;
   wwg_pkg::cell_type     expected_cell;

   wireworld_grid_engine_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_new_state  (req_new_state),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_state (rsp_cell_state),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run timed out", $time);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
   end

   // compare every taken result word with the oldest predicted read
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cell_reads.size() == 0) begin
            $display("%0t: result word with no read pending, actual %0d",
                     $time, rsp_cell_state);
            mismatch_count++;
         end else begin
            expected_cell = pending_cell_reads.pop_front();
            if (rsp_cell_state !== expected_cell) begin
               $display("%0t: cell_state mismatch, expected %0d actual %0d",
                        $time, expected_cell, rsp_cell_state);
               mismatch_count++;
            end
         end
      end
   end

   function automatic int clamp_span(input int used, input int lim);
      return used > lim ? lim : used;
   endfunction

   // span used to aim random addresses; an empty region aims at the whole grid
   function automatic int aim_span(input int used, input int lim);
      return (used == 0 || used > lim) ? lim : used;
   endfunction

   function automatic void advance_generation();
      wwg_pkg::cell_type next_cells [GRID_ROWS][GRID_COLS];
      int       nr, nc, heads, r, c, dr, dc, rr, cc;
      nr = clamp_span(int'(rows_cfg), GRID_ROWS);
      nc = clamp_span(int'(cols_cfg), GRID_COLS);
      for (r = 0; r < nr; r++) begin
         for (c = 0; c < nc; c++) begin
            heads = 0;
            for (dr = -1; dr <= 1; dr++) begin
               for (dc = -1; dc <= 1; dc++) begin
                  rr = r + dr;
                  cc = c + dc;
                  if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc &&
                      grid_model[rr][cc] == wwg_pkg::CELL_HEAD)
                     heads++;
               end
            end
            case (grid_model[r][c])
               wwg_pkg::CELL_COND:
                  next_cells[r][c] = (heads == 1 || heads == 2) ? wwg_pkg::CELL_HEAD
                                                                : wwg_pkg::CELL_COND;
               wwg_pkg::CELL_HEAD: next_cells[r][c] = wwg_pkg::CELL_TAIL;
               wwg_pkg::CELL_TAIL: next_cells[r][c] = wwg_pkg::CELL_COND;
               default:            next_cells[r][c] = wwg_pkg::CELL_EMPTY;
            endcase
         end
      end
      for (r = 0; r < nr; r++)
         for (c = 0; c < nc; c++)
            grid_model[r][c] = next_cells[r][c];
   endfunction

   task automatic send_word(input wwg_pkg::op_type op, input int row, input int col,
                            input wwg_pkg::cell_type ns);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_row       <= row[4:0];
      req_col       <= col[5:0];
      req_new_state <= ns;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (op)
         wwg_pkg::OP_WRITE: grid_model[row][col] = ns;
         wwg_pkg::OP_STEP:  advance_generation();
         wwg_pkg::OP_READ:  pending_cell_reads.push_back(grid_model[row][col]);
         default: ;
      endcase
   endtask

   task automatic write_region_reg(input logic [wwg_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [wwg_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == wwg_pkg::CSR_ROWS_USED)
         rows_cfg = data[wwg_pkg::ROWS_USED_W-1:0];
      else if (idx == wwg_pkg::CSR_COLS_USED)
         cols_cfg = data[wwg_pkg::COLS_USED_W-1:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drop valid, wait for every read word, then let a full sweep run out
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_cell_reads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_grid();
      send_word(wwg_pkg::OP_READ, 0, 0, wwg_pkg::CELL_HEAD);
      send_word(wwg_pkg::OP_READ, GRID_ROWS - 1, GRID_COLS - 1, wwg_pkg::CELL_TAIL);
   endtask

   task automatic test_cell_access();
      send_word(wwg_pkg::OP_WRITE, GRID_ROWS - 1, GRID_COLS - 1, wwg_pkg::CELL_TAIL);
      send_word(wwg_pkg::OP_NOP, GRID_ROWS - 1, GRID_COLS - 1, wwg_pkg::CELL_EMPTY);
      send_word(wwg_pkg::OP_READ, GRID_ROWS - 1, GRID_COLS - 1, wwg_pkg::CELL_EMPTY);
   endtask

   // one, two and three head neighbors, plus both edges of the 20x40 reset region
   task automatic test_generation_rules();
      send_word(wwg_pkg::OP_WRITE, 0, 0, wwg_pkg::CELL_TAIL);
      send_word(wwg_pkg::OP_WRITE, 0, 1, wwg_pkg::CELL_COND);
      send_word(wwg_pkg::OP_WRITE, 0, 2, wwg_pkg::CELL_HEAD);
      send_word(wwg_pkg::OP_WRITE, 1, 0, wwg_pkg::CELL_HEAD);
      send_word(wwg_pkg::OP_WRITE, 1, 1, wwg_pkg::CELL_COND);
      send_word(wwg_pkg::OP_WRITE, 2, 1, wwg_pkg::CELL_COND);
      send_word(wwg_pkg::OP_WRITE, 2, 2, wwg_pkg::CELL_HEAD);
      send_word(wwg_pkg::OP_WRITE, 3, 3, wwg_pkg::CELL_COND);
      send_word(wwg_pkg::OP_WRITE, 19, 39, wwg_pkg::CELL_COND);
      send_word(wwg_pkg::OP_WRITE, 19, 40, wwg_pkg::CELL_HEAD);
      send_word(wwg_pkg::OP_WRITE, 20, 6, wwg_pkg::CELL_HEAD);
      send_word(wwg_pkg::OP_WRITE, 19, 6, wwg_pkg::CELL_COND);
      send_word(wwg_pkg::OP_STEP, 0, 0, wwg_pkg::CELL_EMPTY);
      send_word(wwg_pkg::OP_READ, 0, 0, wwg_pkg::CELL_EMPTY);
      send_word(wwg_pkg::OP_READ, 0, 1, wwg_pkg::CELL_EMPTY);
      send_word(wwg_pkg::OP_READ, 1, 1, wwg_pkg::CELL_EMPTY);
      send_word(wwg_pkg::OP_READ, 2, 1, wwg_pkg::CELL_EMPTY);
      send_word(wwg_pkg::OP_READ, 2, 2, wwg_pkg::CELL_EMPTY);
      send_word(wwg_pkg::OP_READ, 3, 3, wwg_pkg::CELL_EMPTY);
      send_word(wwg_pkg::OP_READ, 19, 39, wwg_pkg::CELL_EMPTY);
      send_word(wwg_pkg::OP_READ, 19, 40, wwg_pkg::CELL_EMPTY);
      send_word(wwg_pkg::OP_READ, 19, 6, wwg_pkg::CELL_EMPTY);
      send_word(wwg_pkg::OP_READ, 20, 6, wwg_pkg::CELL_EMPTY);
   endtask

   // mostly short wires with a head at one end, stepped and probed; the rest is noise
   task automatic run_traffic(input int n_words);
      int sent, rows_span, cols_span, base_row, base_col, len, k, n_steps, n_reads, s, q;
      int rd_row, rd_col;
      sent      = 0;
      rows_span = aim_span(int'(rows_cfg), GRID_ROWS);
      cols_span = aim_span(int'(cols_cfg), GRID_COLS);
      while (sent < n_words) begin
         if ($urandom_range(99) < 70) begin
            base_row = $urandom_range(rows_span - 1);
            base_col = $urandom_range(cols_span - 1);
            len      = $urandom_range(2, 8);
            if (base_col > 0 && $urandom_range(1)) begin
               send_word(wwg_pkg::OP_WRITE, base_row, base_col - 1, wwg_pkg::CELL_TAIL);
               sent++;
            end
            for (k = 0; k < len && base_col + k < GRID_COLS; k++) begin
               send_word(wwg_pkg::OP_WRITE, base_row, base_col + k,
                         k == 0 ? wwg_pkg::CELL_HEAD : wwg_pkg::CELL_COND);
               sent++;
            end
            if ($urandom_range(2) == 0 && base_row + 1 < GRID_ROWS &&
                base_col + 2 < GRID_COLS) begin
               send_word(wwg_pkg::OP_WRITE, base_row + 1, base_col + 2, wwg_pkg::CELL_COND);
               sent++;
            end
            n_steps = $urandom_range(1, 3);
            for (s = 0; s < n_steps; s++) begin
               send_word(wwg_pkg::OP_STEP, $urandom_range(GRID_ROWS - 1),
                         $urandom_range(GRID_COLS - 1),
                         wwg_pkg::cell_type'($urandom_range(3)));
               sent++;
               n_reads = $urandom_range(1, 2);
               for (q = 0; q < n_reads; q++) begin
                  rd_row = base_row - 1 + int'($urandom_range(2));
                  rd_col = base_col + int'($urandom_range(len));
                  if (rd_row < 0) rd_row = 0;
                  if (rd_row >= GRID_ROWS) rd_row = GRID_ROWS - 1;
                  if (rd_col >= GRID_COLS) rd_col = GRID_COLS - 1;
                  send_word(wwg_pkg::OP_READ, rd_row, rd_col,
                            wwg_pkg::cell_type'($urandom_range(3)));
                  sent++;
               end
            end
         end else begin
            send_word(wwg_pkg::op_type'($urandom_range(3)), $urandom_range(GRID_ROWS - 1),
                      $urandom_range(GRID_COLS - 1), wwg_pkg::cell_type'($urandom_range(3)));
            sent++;
         end
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct,
                            input logic [wwg_pkg::CSR_DATA_W-1:0] rows_word,
                            input logic [wwg_pkg::CSR_DATA_W-1:0] cols_word,
                            input int n_words);
      drain_and_settle();
      write_region_reg(wwg_pkg::CSR_ROWS_USED, rows_word);
      write_region_reg(wwg_pkg::CSR_COLS_USED, cols_word);
      // spare indexes must leave both registers alone
      write_region_reg(phase_count % 2 ? CSR_IDX_SPARE_HI : CSR_IDX_SPARE_LO,
                       wwg_pkg::CSR_DATA_W'($urandom_range(127)));
      phase_count++;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      run_traffic(n_words);
   endtask

   task automatic test_region_sweep();
      run_phase(0,  0,  7'd3,   7'd5,   30);
      run_phase(84, 0,  7'd1,   7'd64,  30);
      // 100 masks to 36 rows, then clamps to the grid height
      run_phase(0,  84, 7'd100, 7'd127, 30);
      run_phase(25, 25, 7'd0,   7'd9,   30);
      run_phase(0,  0,  7'd6,   7'd0,   30);
      run_phase(25, 25, 7'd63,  7'd1,   30);
      run_phase(0,  84, 7'd12,  7'd33,  30);
      run_phase(84, 0,  7'd32,  7'd64,  30);
   endtask

   initial begin
      for (int r = 0; r < GRID_ROWS; r++)
         for (int c = 0; c < GRID_COLS; c++)
            grid_model[r][c] = wwg_pkg::CELL_EMPTY;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_grid();
      test_cell_access();
      test_generation_rules();
      test_region_sweep();
      req_valid <= 1'b0;
      while (pending_cell_reads.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
